@@ rtl/tvg_pkg.sv @@
// Shared constants, types and helpers for the torus vertex generator.
package tvg_pkg;

    localparam int ANGLE_BITS = 16;
    localparam int INDEX_BITS = 10;
    localparam int REG_W      = 16;
    localparam int OUT_W      = 18;
    localparam int SC_W       = 32;

    localparam logic [REG_W-1:0] MAJOR_RST     = 16'd256;
    localparam logic [REG_W-1:0] MINOR_RST     = 16'd256;
    localparam logic [REG_W-1:0] THETA_RST     = 16'd65535;
    localparam logic [REG_W-1:0] PHI_STEP_RST  = 16'd13107;
    localparam logic [REG_W-1:0] PHI_START_RST = 16'd182;

    typedef enum logic [2:0] {
        CFG_MAJOR     = 3'd0,
        CFG_MINOR     = 3'd1,
        CFG_THETA     = 3'd2,
        CFG_PHI_STEP  = 3'd3,
        CFG_PHI_START = 3'd4
    } t_cfg_idx;

    localparam logic [30:0] ONE_Q30 = 31'd1 << 30;
    localparam logic [29:0] PI4_Q30 = 30'd843314857;

    // floor(x/d) = (x*M) >> K, exact for dividends below 2^31
    localparam int K42 = 37;
    localparam int K20 = 36;
    localparam int K6  = 34;
    localparam int K56 = 37;
    localparam int K30 = 36;
    localparam int K12 = 35;
    localparam logic [31:0] M42 = 32'(((64'd1 << K42) + 64'd41) / 64'd42);
    localparam logic [31:0] M20 = 32'(((64'd1 << K20) + 64'd19) / 64'd20);
    localparam logic [31:0] M6  = 32'(((64'd1 << K6)  + 64'd5)  / 64'd6);
    localparam logic [31:0] M56 = 32'(((64'd1 << K56) + 64'd55) / 64'd56);
    localparam logic [31:0] M30 = 32'(((64'd1 << K30) + 64'd29) / 64'd30);
    localparam logic [31:0] M12 = 32'(((64'd1 << K12) + 64'd11) / 64'd12);

    typedef struct packed {
        logic signed [SC_W-1:0] sin_v;
        logic signed [SC_W-1:0] cos_v;
    } t_sc;

    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [31:0] v);
        logic signed [OUT_W-1:0] res;
        if (v > 32'sd131071) begin
            res = 18'sd131071;
        end else if (v < -32'sd131072) begin
            res = -18'sd131072;
        end else begin
            res = OUT_W'(v);
        end
        return res;
    endfunction

endpackage

@@ rtl/tvg_sincos.sv @@
// Pipelined fixed-point sine/cosine of a turn-fraction angle, Q30 results.
module tvg_sincos (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic [tvg_pkg::ANGLE_BITS-1:0]  i_angle,
    output logic                            o_valid,
    output tvg_pkg::t_sc                    o_sc
);

    logic [31:0] phase;
    logic [29:0] frac;
    logic [30:0] oct_a;
    logic [60:0] prod_y;

    logic [8:1]  r_v;
    logic [1:0]  r_quad [1:8];
    logic        r_half [1:8];
    logic [29:0] r_y    [1:7];
    logic [29:0] r_q    [2:7];

    logic [62:0] r_ds3, r_dc3, r_ds5, r_dc5, r_ds7, r_dc7;
    logic [60:0] r_ps4, r_pc4, r_ps6, r_pc6, r_pc8;
    logic [30:0] r_s8;

    logic [30:0] h1s, h1c, h2s, h2c, h3s, h3c;
    logic [60:0] prod_s8;
    logic [30:0] c_fin;
    logic signed [31:0] s_oct, c_oct, s_sw, c_sw;
    logic signed [31:0] n_sin, n_cos;

    assign phase = {i_angle, {(32 - tvg_pkg::ANGLE_BITS){1'b0}}};
    assign frac  = phase[29:0];
    // mirror the upper half of the quadrant into the first octant
    assign oct_a = frac[29] ? 31'((tvg_pkg::ONE_Q30 - 31'(frac)) << 1) : {frac, 1'b0};
    assign prod_y = 61'(oct_a) * 61'(tvg_pkg::PI4_Q30);

    assign h1s = tvg_pkg::ONE_Q30 - 31'(r_ds3 >> tvg_pkg::K42);
    assign h1c = tvg_pkg::ONE_Q30 - 31'(r_dc3 >> tvg_pkg::K56);
    assign h2s = tvg_pkg::ONE_Q30 - 31'(r_ds5 >> tvg_pkg::K20);
    assign h2c = tvg_pkg::ONE_Q30 - 31'(r_dc5 >> tvg_pkg::K30);
    assign h3s = tvg_pkg::ONE_Q30 - 31'(r_ds7 >> tvg_pkg::K6);
    assign h3c = tvg_pkg::ONE_Q30 - 31'(r_dc7 >> tvg_pkg::K12);
    assign prod_s8 = 61'(r_y[7]) * 61'(h3s);

    assign c_fin = tvg_pkg::ONE_Q30 - 31'(r_pc8[60:31]);

    always_comb begin
        s_oct = $signed({1'b0, r_s8});
        c_oct = $signed({1'b0, c_fin});
        if (r_half[8]) begin
            s_sw = c_oct;
            c_sw = s_oct;
        end else begin
            s_sw = s_oct;
            c_sw = c_oct;
        end
        case (r_quad[8])
            2'd0: begin
                n_sin = s_sw;
                n_cos = c_sw;
            end
            2'd1: begin
                n_sin = c_sw;
                n_cos = -s_sw;
            end
            2'd2: begin
                n_sin = -s_sw;
                n_cos = -c_sw;
            end
            default: begin
                n_sin = -c_sw;
                n_cos = s_sw;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v     <= '0;
            o_valid <= 1'b0;
        end else begin
            r_v     <= {r_v[7:1], i_valid};
            o_valid <= r_v[8];
        end
    end

    always_ff @(posedge i_clk) begin
        r_quad[1] <= phase[31:30];
        r_half[1] <= frac[29];
        r_y[1]    <= prod_y[59:30];
        for (int k = 2; k <= 8; k++) begin
            r_quad[k] <= r_quad[k-1];
            r_half[k] <= r_half[k-1];
        end
        for (int k = 2; k <= 7; k++) begin
            r_y[k] <= r_y[k-1];
        end
        r_q[2] <= 30'((61'(r_y[1]) * 61'(r_y[1])) >> 30);
        for (int k = 3; k <= 7; k++) begin
            r_q[k] <= r_q[k-1];
        end
        r_ds3 <= 63'(r_q[2]) * 63'(tvg_pkg::M42);
        r_dc3 <= 63'(r_q[2]) * 63'(tvg_pkg::M56);
        r_ps4 <= 61'(r_q[3]) * 61'(h1s);
        r_pc4 <= 61'(r_q[3]) * 61'(h1c);
        r_ds5 <= 63'(r_ps4[60:30]) * 63'(tvg_pkg::M20);
        r_dc5 <= 63'(r_pc4[60:30]) * 63'(tvg_pkg::M30);
        r_ps6 <= 61'(r_q[5]) * 61'(h2s);
        r_pc6 <= 61'(r_q[5]) * 61'(h2c);
        r_ds7 <= 63'(r_ps6[60:30]) * 63'(tvg_pkg::M6);
        r_dc7 <= 63'(r_pc6[60:30]) * 63'(tvg_pkg::M12);
        r_s8  <= prod_s8[60:30];
        r_pc8 <= 61'(r_q[7]) * 61'(h3c);
        o_sc.sin_v <= n_sin;
        o_sc.cos_v <= n_cos;
    end

    a_zero_angle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_angle == '0) |-> ##9
        (o_valid && o_sc.cos_v == 32'sd1073741824 && o_sc.sin_v == 32'sd0))
        else $error("zero angle does not give unit cosine");

    a_sc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_sc.sin_v <= 32'sd1073741824 && o_sc.sin_v >= -32'sd1073741824
                     && o_sc.cos_v <= 32'sd1073741824 && o_sc.cos_v >= -32'sd1073741824))
        else $error("sine or cosine beyond unit magnitude");

endmodule

@@ rtl/tvg_datapath.sv @@
// Radius scaling, rounding and saturation of the vertex coordinates.
module tvg_datapath (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    input  tvg_pkg::t_sc                            i_sc_t,
    input  tvg_pkg::t_sc                            i_sc_u,
    input  logic [tvg_pkg::REG_W-1:0]               i_major,
    input  logic [tvg_pkg::REG_W-1:0]               i_minor,
    output logic                                    o_valid,
    output logic signed [tvg_pkg::OUT_W-1:0]        o_pos_x,
    output logic signed [tvg_pkg::OUT_W-1:0]        o_pos_y,
    output logic signed [tvg_pkg::OUT_W-1:0]        o_pos_z
);

    logic [3:1] r_v;

    logic signed [48:0] mr_c, mz_c;
    logic signed [47:0] r_mr, r_mz;
    logic signed [31:0] r_ct1, r_st1, r_ct2, r_st2;
    logic [tvg_pkg::REG_W-1:0] r_major1;

    logic signed [48:0] sum_w, sum_z;
    logic signed [26:0] r_w;
    logic signed [tvg_pkg::OUT_W-1:0] r_z2, r_z3;

    logic signed [58:0] r_px, r_py;
    logic signed [58:0] rx, ry;

    assign mr_c = $signed({1'b0, i_minor}) * i_sc_u.cos_v;
    assign mz_c = $signed({1'b0, i_minor}) * i_sc_u.sin_v;

    assign sum_w = $signed({3'b000, r_major1, 30'd0}) + 49'(r_mr) + 49'sd2097152;
    assign sum_z = -49'(r_mz) + 49'sd536870912;

    assign rx = (r_px + 59'sd137438953472) >>> 38;
    assign ry = (r_py + 59'sd137438953472) >>> 38;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v     <= '0;
            o_valid <= 1'b0;
        end else begin
            r_v     <= {r_v[2:1], i_valid};
            o_valid <= r_v[3];
        end
    end

    always_ff @(posedge i_clk) begin
        r_mr     <= 48'(mr_c);
        r_mz     <= 48'(mz_c);
        r_ct1    <= i_sc_t.cos_v;
        r_st1    <= i_sc_t.sin_v;
        r_major1 <= i_major;

        r_w   <= 27'(sum_w >>> 22);
        r_z2  <= tvg_pkg::sat_out(32'(sum_z >>> 30));
        r_ct2 <= r_ct1;
        r_st2 <= r_st1;

        r_px <= 59'(r_w) * 59'(r_ct2);
        r_py <= 59'(r_w) * 59'(r_st2);
        r_z3 <= r_z2;

        o_pos_x <= tvg_pkg::sat_out(32'(rx));
        o_pos_y <= tvg_pkg::sat_out(32'(ry));
        o_pos_z <= r_z3;
    end

    // tube radius times a unit sine never leaves +-65535
    a_z_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_pos_z <= 18'sd65535 && o_pos_z >= -18'sd65535))
        else $error("z coordinate beyond tube radius");

endmodule

@@ rtl/torus_vertex_generator_top.sv @@
// Top level of the torus vertex generator: config registers, angle stage, trig and datapath.
//
// Usage:
//   A request is taken at a rising edge where start is high and busy is low.
//   busy is never raised: the pipeline takes one index pair every clock.
//   Each request gives one vertex (o_pos_x, o_pos_y, o_pos_z, signed Q9.8),
//   shown for a single cycle with o_valid high.
//   Sustained rate is one vertex per clock through 14 register stages:
//   angle multiply, nine of sine/cosine (eight multiply stages and the
//   quadrant fold) and four of scaling.
//   The receiver has no back-pressure, so results are never held.
//   Configuration: i_cfg_valid/o_cfg_ready write channel, index 0..4 selects
//   major radius, tube radius, ring step, tube step, tube start. Other
//   indexes are ignored. Write only while no request is in flight.
//   Reset (i_rst_n low, synchronous) empties the pipeline and restores the
//   default radii, angle steps and tube start.
module torus_vertex_generator_top (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    start,
    output logic                                    busy,
    input  logic [tvg_pkg::INDEX_BITS-1:0]          i_ring,
    input  logic [tvg_pkg::INDEX_BITS-1:0]          i_segment,
    output logic                                    o_valid,
    output logic signed [tvg_pkg::OUT_W-1:0]        o_pos_x,
    output logic signed [tvg_pkg::OUT_W-1:0]        o_pos_y,
    output logic signed [tvg_pkg::OUT_W-1:0]        o_pos_z,
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic [2:0]                              i_cfg_index,
    input  logic [tvg_pkg::REG_W-1:0]               i_cfg_data
);

    localparam int AB = tvg_pkg::ANGLE_BITS;

    logic [tvg_pkg::REG_W-1:0] r_major, r_minor, r_theta, r_phi_step, r_phi_start;
    logic [AB-1:0] theta_a, phi_step_a, phi_start_a;
    logic [AB-1:0] n_t, n_u;
    logic [AB-1:0] r_t, r_u;
    logic          r_va;
    logic          take;

    logic          v_t, v_u;
    tvg_pkg::t_sc  sc_t, sc_u;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign take        = start && !busy;

    assign theta_a     = AB'(r_theta);
    assign phi_step_a  = AB'(r_phi_step);
    assign phi_start_a = AB'(r_phi_start);
    assign n_t = AB'(i_ring * theta_a);
    assign n_u = AB'(phi_start_a + AB'(i_segment * phi_step_a));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_major     <= tvg_pkg::MAJOR_RST;
            r_minor     <= tvg_pkg::MINOR_RST;
            r_theta     <= tvg_pkg::THETA_RST;
            r_phi_step  <= tvg_pkg::PHI_STEP_RST;
            r_phi_start <= tvg_pkg::PHI_START_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (tvg_pkg::t_cfg_idx'(i_cfg_index))
                tvg_pkg::CFG_MAJOR:     r_major     <= i_cfg_data;
                tvg_pkg::CFG_MINOR:     r_minor     <= i_cfg_data;
                tvg_pkg::CFG_THETA:     r_theta     <= i_cfg_data;
                tvg_pkg::CFG_PHI_STEP:  r_phi_step  <= i_cfg_data;
                tvg_pkg::CFG_PHI_START: r_phi_start <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
        end else begin
            r_va <= take;
        end
    end

    always_ff @(posedge i_clk) begin
        r_t <= n_t;
        r_u <= n_u;
    end

    tvg_sincos u_sc_t (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_va),
        .i_angle (r_t),
        .o_valid (v_t),
        .o_sc    (sc_t)
    );

    tvg_sincos u_sc_u (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_va),
        .i_angle (r_u),
        .o_valid (v_u),
        .o_sc    (sc_u)
    );

    tvg_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (v_t && v_u),
        .i_sc_t  (sc_t),
        .i_sc_u  (sc_u),
        .i_major (r_major),
        .i_minor (r_minor),
        .o_valid (o_valid),
        .o_pos_x (o_pos_x),
        .o_pos_y (o_pos_y),
        .o_pos_z (o_pos_z)
    );

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |-> ##14 o_valid)
        else $error("request did not produce a vertex after 14 cycles");

    a_lanes_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        v_t == v_u)
        else $error("ring and tube trig lanes out of step");

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the torus vertex generator: directed table, then random requests.
module tb_top;

    localparam int LATENCY  = 14;
    localparam int WD_LIMIT = 2000;
    localparam int N_RAND   = 1750;
    localparam int N_DIR    = 16;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [tvg_pkg::INDEX_BITS-1:0] i_ring = '0;
    logic [tvg_pkg::INDEX_BITS-1:0] i_segment = '0;
    logic o_valid;
    logic signed [tvg_pkg::OUT_W-1:0] o_pos_x, o_pos_y, o_pos_z;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [2:0] i_cfg_index = '0;
    logic [tvg_pkg::REG_W-1:0] i_cfg_data = '0;

    typedef struct packed {
        logic signed [tvg_pkg::OUT_W-1:0] x;
        logic signed [tvg_pkg::OUT_W-1:0] y;
        logic signed [tvg_pkg::OUT_W-1:0] z;
    } t_vertex;

    typedef struct {
        logic [tvg_pkg::INDEX_BITS-1:0] ring;
        logic [tvg_pkg::INDEX_BITS-1:0] seg;
        bit                             known;
        t_vertex                        vtx;
    } t_row;

    // shadow copies of the configuration registers
    logic [tvg_pkg::REG_W-1:0] m_major, m_minor, m_theta, m_phi_step, m_phi_start;

    t_vertex vertex_q[$];
    int      n_errors = 0;
    int      idle_cnt = 0;
    bit      no_idle = 1'b0;
    t_row    rows[N_DIR];

    torus_vertex_generator_top dut (.*);

    always #4 i_clk = ~i_clk;

    // octant polynomial: returns s,c in Q30 for a in [0, 2^30]
    function automatic void octant_sc(input longint unsigned a,
                                      output longint unsigned sn, output longint unsigned cs);
        longint unsigned y, q, h, one;
        one = 64'd1 << 30;
        y = (a * 64'd843314857) >> 30;
        q = (y * y) >> 30;
        h = one - q / 42;
        h = one - ((q * h) >> 30) / 20;
        h = one - ((q * h) >> 30) / 6;
        sn = (y * h) >> 30;
        h = one - q / 56;
        h = one - ((q * h) >> 30) / 30;
        h = one - ((q * h) >> 30) / 12;
        cs = one - ((q * h) >> 30) / 2;
    endfunction

    function automatic void angle_sc(input logic [tvg_pkg::ANGLE_BITS-1:0] ang,
                                     output longint sv, output longint cv);
        logic [31:0]     p;
        longint unsigned f, s0, c0;
        longint          s, c;
        p = 32'(ang) << (32 - tvg_pkg::ANGLE_BITS);
        f = longint'(p[29:0]);
        if (f < (64'd1 << 29)) begin
            octant_sc(f << 1, s0, c0);
            s = s0; c = c0;
        end else begin
            octant_sc(((64'd1 << 30) - f) << 1, s0, c0);
            s = c0; c = s0;
        end
        case (p[31:30])
            2'd0: begin sv = s;  cv = c;  end
            2'd1: begin sv = c;  cv = -s; end
            2'd2: begin sv = -s; cv = -c; end
            default: begin sv = -c; cv = s; end
        endcase
    endfunction

    function automatic longint rnd_shift(input longint v, input int n);
        return (v + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    function automatic logic signed [tvg_pkg::OUT_W-1:0] clip18(input longint v);
        if (v > 131071) return 18'sd131071;
        if (v < -131072) return -18'sd131072;
        return tvg_pkg::OUT_W'(v);
    endfunction

    function automatic t_vertex torus_point(input logic [tvg_pkg::INDEX_BITS-1:0] ring,
                                            input logic [tvg_pkg::INDEX_BITS-1:0] seg);
        logic [tvg_pkg::ANGLE_BITS-1:0] t, u;
        longint st, ct, su, cu, w;
        t_vertex v;
        t = tvg_pkg::ANGLE_BITS'(ring * m_theta);
        u = tvg_pkg::ANGLE_BITS'(m_phi_start + seg * m_phi_step);
        angle_sc(t, st, ct);
        angle_sc(u, su, cu);
        w = rnd_shift((longint'(m_major) <<< 30) + longint'(m_minor) * cu, 22);
        v.x = clip18(rnd_shift(w * ct, 38));
        v.y = clip18(rnd_shift(w * st, 38));
        v.z = clip18(rnd_shift(-(longint'(m_minor) * su), 30));
        return v;
    endfunction

    task automatic maybe_idle();
        if (!no_idle && $urandom_range(99) < 8) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
    endtask

    task automatic send_request(input logic [tvg_pkg::INDEX_BITS-1:0] ring,
                                input logic [tvg_pkg::INDEX_BITS-1:0] seg,
                                input bit known, input t_vertex vtx);
        maybe_idle();
        start     <= 1'b1;
        i_ring    <= ring;
        i_segment <= seg;
        do @(posedge i_clk); while (busy);
        vertex_q.push_back(known ? vtx : torus_point(ring, seg));
        @(negedge i_clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (vertex_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // leaves valid high; load_config drops it after the last write
    task automatic write_reg(input tvg_pkg::t_cfg_idx idx,
                             input logic [tvg_pkg::REG_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            tvg_pkg::CFG_MAJOR:     m_major     = val;
            tvg_pkg::CFG_MINOR:     m_minor     = val;
            tvg_pkg::CFG_THETA:     m_theta     = val;
            tvg_pkg::CFG_PHI_STEP:  m_phi_step  = val;
            tvg_pkg::CFG_PHI_START: m_phi_start = val;
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic load_config(input logic [tvg_pkg::REG_W-1:0] r_maj,
                               input logic [tvg_pkg::REG_W-1:0] r_min,
                               input logic [tvg_pkg::REG_W-1:0] th,
                               input logic [tvg_pkg::REG_W-1:0] ps,
                               input logic [tvg_pkg::REG_W-1:0] p0);
        write_reg(tvg_pkg::CFG_MAJOR, r_maj);
        write_reg(tvg_pkg::CFG_MINOR, r_min);
        write_reg(tvg_pkg::CFG_THETA, th);
        write_reg(tvg_pkg::CFG_PHI_STEP, ps);
        write_reg(tvg_pkg::CFG_PHI_START, p0);
        i_cfg_valid <= 1'b0;
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_vertex e;
        if (i_rst_n && o_valid) begin
            if (vertex_q.size() == 0) begin
                $error("unexpected vertex x=%0d y=%0d z=%0d", o_pos_x, o_pos_y, o_pos_z);
                n_errors++;
            end else begin
                e = vertex_q.pop_front();
                if (o_pos_x !== e.x) begin
                    $error("pos_x expected %0d got %0d", e.x, o_pos_x); n_errors++;
                end
                if (o_pos_y !== e.y) begin
                    $error("pos_y expected %0d got %0d", e.y, o_pos_y); n_errors++;
                end
                if (o_pos_z !== e.z) begin
                    $error("pos_z expected %0d got %0d", e.z, o_pos_z); n_errors++;
                end
            end
        end
    end

    // watchdog on cycles with no accepted request, configuration write or result
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            idle_cnt <= 0;
        else if (idle_cnt >= WD_LIMIT) begin
            $display("FAIL torus_vertex_generator_top");
            $finish;
        end else
            idle_cnt <= idle_cnt + 1;
    end

    initial begin
        int k;
        logic [tvg_pkg::REG_W-1:0] cfg [5];
        m_major = tvg_pkg::MAJOR_RST; m_minor = tvg_pkg::MINOR_RST;
        m_theta = tvg_pkg::THETA_RST;
        m_phi_step = tvg_pkg::PHI_STEP_RST; m_phi_start = tvg_pkg::PHI_START_RST;

        // directed rows; known vertices follow straight from the formula
        rows[0]  = '{10'd0, 10'd0, 1'b0, '0};
        rows[1]  = '{10'd1023, 10'd1023, 1'b0, '0};
        rows[2]  = '{10'd1, 10'd5, 1'b0, '0};
        rows[3]  = '{10'd512, 10'd512, 1'b0, '0};
        rows[4]  = '{10'h2AA, 10'h155, 1'b0, '0};
        rows[5]  = '{10'h155, 10'h2AA, 1'b0, '0};
        // radii zero: origin regardless of angles
        rows[6]  = '{10'd0, 10'd0, 1'b1, '0};
        rows[7]  = '{10'd1023, 10'd777, 1'b1, '0};
        // full radii, all angles zero: x = R + r, y = z = 0 (Q8.8 -> Q9.8)
        rows[8]  = '{10'd0, 10'd0, 1'b1, '{18'sd131070, 18'sd0, 18'sd0}};
        rows[9]  = '{10'd1023, 10'd1023, 1'b0, '0};
        rows[10] = '{10'd3, 10'd9, 1'b0, '0};
        rows[11] = '{10'd700, 10'd100, 1'b0, '0};
        rows[12] = '{10'd4, 10'd4, 1'b0, '0};
        rows[13] = '{10'd8, 10'd2, 1'b0, '0};
        rows[14] = '{10'd1000, 10'd1000, 1'b0, '0};
        rows[15] = '{10'd2, 10'd6, 1'b0, '0};

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (k = 0; k < N_DIR; k++) begin
            if (k == 6) begin
                drain();
                load_config(16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
            end else if (k == 8) begin
                drain();
                load_config(16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'd0);
            end else if (k == 9) begin
                drain();
                load_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
            end else if (k == 12) begin
                drain();
                // quarter and eighth turns hit the quadrant and octant joins
                load_config(16'd1000, 16'd300, 16'h4000, 16'h2000, 16'h0000);
            end
            send_request(rows[k].ring, rows[k].seg, rows[k].known, rows[k].vtx);
        end

        for (k = 0; k < N_RAND; k++) begin
            if (k % 250 == 0) begin
                drain();
                cfg[0] = tvg_pkg::REG_W'($urandom); cfg[1] = tvg_pkg::REG_W'($urandom);
                cfg[2] = tvg_pkg::REG_W'($urandom); cfg[3] = tvg_pkg::REG_W'($urandom);
                cfg[4] = tvg_pkg::REG_W'($urandom);
                if (k == 500) begin cfg[0] = 16'hFFFF; cfg[1] = 16'hFFFF; end
                if (k == 750) begin cfg[0] = 16'd0; cfg[1] = 16'hFFFF; end
                load_config(cfg[0], cfg[1], cfg[2], cfg[3], cfg[4]);
            end
            no_idle = (k >= 1000 && k < 1250);
            send_request(tvg_pkg::INDEX_BITS'($urandom), tvg_pkg::INDEX_BITS'($urandom),
                         1'b0, '0);
        end
        drain();

        if (n_errors == 0 && vertex_q.size() == 0)
            $display("PASS torus_vertex_generator_top");
        else
            $display("FAIL torus_vertex_generator_top");
        $finish;
    end
endmodule
